// ----- src/otb_pkg.sv -----
`default_nettype none

package otb_pkg;

    // item modes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;
    localparam logic [1:0] MODE_SCAN   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam int unsigned CNT_W = 32;
    localparam int unsigned ID_W  = 8;

    typedef struct packed {
        logic [1:0]       mode;
        logic [ID_W-1:0]  timer_id;
        logic [CNT_W-1:0] delay_ticks;
    } otb_in_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ID_W-1:0]  fired_id;
        logic [CNT_W-1:0] now_ticks;
        logic             last;
    } otb_out_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SCAN_END
    } state_t;

    // slot store update command
    typedef struct packed {
        logic             write_deadline;
        logic             set_armed;
        logic             clr_armed;
        logic [ID_W-1:0]  slot;
        logic [CNT_W-1:0] deadline;
    } store_cmd_t;

endpackage

`default_nettype wire

// ----- src/otb_alu.sv -----
`default_nettype none

module otb_alu
    import otb_pkg::*;
(
    input  wire alu_op_t          op,
    input  wire logic [CNT_W-1:0] a,
    input  wire logic [CNT_W-1:0] b,
    output logic      [CNT_W-1:0] y
);

    // shared 32-bit adder, subtract by two's complement of b
    always_comb
    begin
        unique case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a + ~b + CNT_W'(1);
            default: y = a + b;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/otb_slot_store.sv -----
`default_nettype none

module otb_slot_store
    import otb_pkg::*;
#(
    parameter int NUM_SLOTS = 8,
    parameter int IDX_W     = 3
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire store_cmd_t        cmd,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output logic      [CNT_W-1:0]  rd_data,
    output logic [NUM_SLOTS-1:0]   armed
);

    logic [NUM_SLOTS-1:0] armed_reg;
    logic [CNT_W-1:0]     deadline_mem [NUM_SLOTS];
    logic [CNT_W-1:0]     rd_data_reg;
    logic [IDX_W-1:0]     slot_idx;

    assign slot_idx = cmd.slot[IDX_W-1:0];

    // armed flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= '0;
        end
        else
        begin
            priority if (cmd.set_armed)
            begin
                armed_reg[slot_idx] <= 1'b1;
            end
            else if (cmd.clr_armed)
            begin
                armed_reg[slot_idx] <= 1'b0;
            end
        end
    end

    // deadline memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.write_deadline)
        begin
            deadline_mem[slot_idx] <= cmd.deadline;
        end
        if (rd_en)
        begin
            rd_data_reg <= deadline_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign armed   = armed_reg;

endmodule

`default_nettype wire

// ----- src/oneshot_timer_bank_core.sv -----
`default_nettype none

// tick, start and cancel: the exec state computes the result, which is registered
// scan: one slot compared per cycle on the shared adder, then the scan end state;
// a hit is strobed when the next hit or the scan end is found; busy meanwhile
// results cannot be stalled, each is valid for the single strobe cycle
// reset: async active low, counter and armed flags cleared, deadlines unset

module oneshot_timer_bank_core
    import otb_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           start,
    output logic          busy,
    input  wire otb_in_t  item,
    output logic          result_strobe,
    output otb_out_t      result
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    state_t           state_reg, state_next;
    otb_in_t          item_reg, item_next;
    logic [CNT_W-1:0] now_reg, now_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_id_reg, pend_id_next;
    logic             strobe_reg, strobe_next;
    otb_out_t         result_reg, result_next;

    alu_op_t              alu_op;
    logic [CNT_W-1:0]     alu_a;
    logic [CNT_W-1:0]     alu_b;
    logic [CNT_W-1:0]     alu_y;
    store_cmd_t           cmd;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [CNT_W-1:0]     rd_data;
    logic [NUM_SLOTS-1:0] armed;
    logic                 id_ok;
    logic                 expired;

    otb_alu u_alu
    (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    otb_slot_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .armed   (armed)
    );

    assign busy    = (state_reg != ST_IDLE);
    assign id_ok   = (item_reg.timer_id < ID_W'(NUM_SLOTS));
    assign expired = armed[idx_reg] && !alu_y[CNT_W-1];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            now_reg    <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            now_reg    <= now_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        pend_id_reg <= pend_id_next;
        result_reg  <= result_next;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        now_next     = now_reg;
        idx_next     = idx_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;
        alu_op       = ALU_ADD;
        alu_a        = now_reg;
        alu_b        = CNT_W'(1);
        cmd          = '0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    if (item.mode == MODE_SCAN)
                    begin
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
                result_next = '{kind: KIND_ACK, fired_id: '0, now_ticks: now_reg, last: 1'b1};
                unique case (item_reg.mode)
                    MODE_TICK:
                    begin
                        now_next              = alu_y;
                        result_next.now_ticks = alu_y;
                    end
                    MODE_START:
                    begin
                        alu_b = item_reg.delay_ticks;
                        if (id_ok)
                        begin
                            cmd.write_deadline = 1'b1;
                            cmd.set_armed      = 1'b1;
                            cmd.slot           = item_reg.timer_id;
                            cmd.deadline       = alu_y;
                        end
                        else
                        begin
                            result_next.kind = KIND_REJECT;
                        end
                    end
                    MODE_CANCEL:
                    begin
                        if (id_ok)
                        begin
                            cmd.clr_armed = 1'b1;
                            cmd.slot      = item_reg.timer_id;
                        end
                    end
                    default:
                    begin
                        result_next.kind = KIND_ACK;
                    end
                endcase
            end

            ST_SCAN:
            begin
                // now - deadline of the slot read last cycle
                alu_op = ALU_SUB;
                alu_b  = rd_data;
                if (expired)
                begin
                    cmd.clr_armed = 1'b1;
                    cmd.slot      = ID_W'(idx_reg);
                    // the previous hit is known not to be the final one
                    if (pend_reg)
                    begin
                        strobe_next = 1'b1;
                        result_next = '{kind: KIND_FIRED, fired_id: ID_W'(pend_id_reg),
                                        now_ticks: now_reg, last: 1'b0};
                    end
                    pend_next    = 1'b1;
                    pend_id_next = idx_reg;
                end
                if (idx_reg == IDX_W'(NUM_SLOTS - 1))
                begin
                    state_next = ST_SCAN_END;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + IDX_W'(1);
                end
            end

            ST_SCAN_END:
            begin
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
                if (pend_reg)
                begin
                    result_next = '{kind: KIND_FIRED, fired_id: ID_W'(pend_id_reg),
                                    now_ticks: now_reg, last: 1'b1};
                end
                else
                begin
                    result_next = '{kind: KIND_NONE, fired_id: '0,
                                    now_ticks: now_reg, last: 1'b1};
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

`default_nettype wire

// ----- src/otb_checker.sv -----
`default_nettype none

module otb_checker
    import otb_pkg::*;
(
    input wire           clk,
    input wire           rst_n,
    input wire           start,
    input wire           busy,
    input wire otb_in_t  item,
    input wire           result_strobe,
    input wire otb_out_t result
);

    // an accepted transfer raises busy
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
    else $error("busy not raised after transfer");

    // more results of the same item follow, so the block stays busy
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last |-> busy)
    else $error("non-final result while idle");

    // only fire results can be non-final
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result.kind != KIND_FIRED) |-> result.last)
    else $error("non-fire result not final");

    // fired_id is zero unless a slot fired
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result.kind != KIND_FIRED) |-> (result.fired_id == '0))
    else $error("fired_id set on non-fire result");

    // a final result is never followed directly by another strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.last |=> !result_strobe)
    else $error("result strobed right after final result");

endmodule

bind oneshot_timer_bank_core otb_checker u_otb_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result)
);

`default_nettype wire
